### rtl/shape_rasterizer_framebuffer_top_assert.svh
// Assertion macros for the shape rasterizer framebuffer checker.
// Needs a clk and an arst_n in the scope of each use.
`ifndef SHAPE_RASTERIZER_FRAMEBUFFER_TOP_ASSERT_SVH
`define SHAPE_RASTERIZER_FRAMEBUFFER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SRFB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SRFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/srfb_pkg.sv
// Shared constants, types and the clip function of the shape rasterizer framebuffer.
// Used by srfb_plot, srfb_draw and the top level; depends on nothing.
package srfb_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 32;
	localparam int COORD_BITS  = 12;

	localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COLOR_W    = 3;
	localparam int KIND_W     = 3;
	localparam int SIZE_W     = 11;
	localparam int CW_W       = 7;
	localparam int CH_W       = 6;
	// plot coordinates after adding offsets or sizes
	localparam int EXT_W      = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;
	localparam int ERR_W      = COORD_BITS + 4;
	localparam int D_W        = SIZE_W + 5;

	localparam logic [KIND_W-1:0] KIND_LINE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RECT  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TRI   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CIRC  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;
	localparam logic [KIND_W-1:0] KIND_READ  = 3'd5;

	localparam logic [CW_W-1:0] CANVAS_W_RESET = 7'd60;
	localparam logic [CH_W-1:0] CANVAS_H_RESET = 6'd20;

	typedef struct packed {
		logic [KIND_W-1:0]            kind;
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] by;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [SIZE_W-1:0]            rw;
		logic [SIZE_W-1:0]            rh;
		logic [SIZE_W-1:0]            rad;
		logic [COLOR_W-1:0]           color;
	} cmd_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               in_range;
	} result_t;

	typedef struct packed {
		logic                    valid;
		logic                    clear;
		logic [ADDR_W-1:0]       clr_addr;
		logic signed [EXT_W-1:0] x;
		logic signed [EXT_W-1:0] y;
		logic [COLOR_W-1:0]      color;
	} plot_req_t;

	typedef struct packed {
		logic signed [EXT_W-1:0] x;
		logic signed [EXT_W-1:0] y;
	} read_req_t;

	typedef struct packed {
		logic               in_canvas;
		logic [COLOR_W-1:0] color;
	} read_rsp_t;

	function automatic logic on_canvas(logic signed [EXT_W-1:0] x, logic signed [EXT_W-1:0] y,
			logic [CW_W-1:0] cw, logic [CH_W-1:0] ch);
		logic [EXT_W-1:0] xu;
		logic [EXT_W-1:0] yu;
		xu = x;
		yu = y;
		return !x[EXT_W-1] && !y[EXT_W-1] && (32'(xu) < 32'(cw)) && (32'(yu) < 32'(ch))
			&& (32'(xu) < MAX_COLUMNS) && (32'(yu) < MAX_ROWS);
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(logic signed [EXT_W-1:0] x,
			logic signed [EXT_W-1:0] y);
		logic [EXT_W-1:0] xu;
		logic [EXT_W-1:0] yu;
		xu = x;
		yu = y;
		return ADDR_W'(32'(yu) * MAX_COLUMNS + 32'(xu));
	endfunction

endpackage

### rtl/srfb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module srfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/srfb_plot.sv
// Cell store port: clips plots against the canvas, writes the store, serves reads.
// Depends on srfb_pkg and srfb_ram.
module srfb_plot (
	input  logic                        clk,
	input  logic                        arst_n,
	input  srfb_pkg::plot_req_t         plot,
	input  srfb_pkg::read_req_t         rd,
	input  logic [srfb_pkg::CW_W-1:0]   cw,
	input  logic [srfb_pkg::CH_W-1:0]   ch,
	output srfb_pkg::read_rsp_t         rsp
);

	srfb_pkg::plot_req_t plot_s1;
	logic                valid_s1;
	logic                inside_s1;
	logic                we;
	logic [srfb_pkg::ADDR_W-1:0]  waddr;
	logic [srfb_pkg::COLOR_W-1:0] wdata;
	logic [srfb_pkg::COLOR_W-1:0] rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= plot.valid;
		end
	end

	always_ff @(posedge clk) begin
		plot_s1   <= plot;
		inside_s1 <= srfb_pkg::on_canvas(rd.x, rd.y, cw, ch);
	end

	always_comb begin
		we    = valid_s1 &&
			(plot_s1.clear || srfb_pkg::on_canvas(plot_s1.x, plot_s1.y, cw, ch));
		waddr = plot_s1.clear ? plot_s1.clr_addr : srfb_pkg::cell_addr(plot_s1.x, plot_s1.y);
		wdata = plot_s1.clear ? '0 : plot_s1.color;
	end

	srfb_ram #(
		.WIDTH(srfb_pkg::COLOR_W),
		.DEPTH(srfb_pkg::CELL_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(srfb_pkg::cell_addr(rd.x, rd.y)),
		.rdata(rdata)
	);

	assign rsp.in_canvas = inside_s1;
	assign rsp.color     = inside_s1 ? rdata : '0;

endmodule

### rtl/srfb_draw.sv
// Command sequencer: line walker, rectangle and circle stepper, clear sweep, cell read.
// Emits at most one plot per cycle into srfb_plot; depends on srfb_pkg.
module srfb_draw (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  srfb_pkg::cmd_t       cmd,
	output logic                 res_valid,
	input  logic                 res_ready,
	output srfb_pkg::result_t    res,
	output srfb_pkg::plot_req_t  plot,
	output srfb_pkg::read_req_t  rd,
	input  srfb_pkg::read_rsp_t  rsp
);

	localparam int CB = srfb_pkg::COORD_BITS;
	localparam int EW = srfb_pkg::EXT_W;
	localparam int RW = srfb_pkg::ERR_W;
	localparam int DW = srfb_pkg::D_W;
	localparam int AW = srfb_pkg::ADDR_W;

	typedef enum logic [9:0] {
		ST_CLEAR  = 10'b0000000001,
		ST_IDLE   = 10'b0000000010,
		ST_LSETUP = 10'b0000000100,
		ST_LINE   = 10'b0000001000,
		ST_RECT_H = 10'b0000010000,
		ST_RECT_V = 10'b0000100000,
		ST_CIRC   = 10'b0001000000,
		ST_READ   = 10'b0010000000,
		ST_RWAIT  = 10'b0100000000,
		ST_DONE   = 10'b1000000000
	} state_t;

	state_t               state_q;
	srfb_pkg::cmd_t       cmd_q;
	srfb_pkg::result_t    res_q;
	logic [AW-1:0]        clr_cnt_q;
	logic                 clr_cmd_q;
	logic signed [CB-1:0] walk_x_q;
	logic signed [CB-1:0] walk_y_q;
	logic signed [RW-1:0] err_q;
	logic [CB-1:0]        dx_q;
	logic [CB-1:0]        dy_q;
	logic                 sx_neg_q;
	logic                 sy_neg_q;
	logic [1:0]           seg_q;
	logic [srfb_pkg::SIZE_W-1:0] i_q;
	logic                 phase_q;
	logic signed [EW-1:0] px_q;
	logic signed [EW-1:0] py_q;
	logic signed [DW-1:0] d_q;
	logic [2:0]           oct_q;

	// line endpoints of the current segment
	logic signed [CB-1:0] x0, y0, x1, y1;
	logic signed [EW-1:0] ddx, ddy;
	logic [CB-1:0]        adx, ady;
	logic signed [RW:0]   twice, pdx, pdy;
	logic                 step_x, step_y, at_end;
	logic signed [EW-1:0] rx, ry, rxe, rye, ccx, ccy;
	logic signed [EW-1:0] cpx, cpy;
	logic                 circ_over;

	always_comb begin
		unique case (seg_q)
			2'd1: begin
				x0 = cmd_q.bx; y0 = cmd_q.by; x1 = cmd_q.cx; y1 = cmd_q.cy;
			end
			2'd2: begin
				x0 = cmd_q.cx; y0 = cmd_q.cy; x1 = cmd_q.ax; y1 = cmd_q.ay;
			end
			default: begin
				x0 = cmd_q.ax; y0 = cmd_q.ay; x1 = cmd_q.bx; y1 = cmd_q.by;
			end
		endcase
		ddx    = EW'(x1) - EW'(x0);
		ddy    = EW'(y1) - EW'(y0);
		adx    = ddx[EW-1] ? CB'(-ddx) : CB'(ddx);
		ady    = ddy[EW-1] ? CB'(-ddy) : CB'(ddy);
		twice  = (RW+1)'(err_q) <<< 1;
		pdx    = (RW+1)'({1'b0, dx_q});
		pdy    = (RW+1)'({1'b0, dy_q});
		step_x = twice > -pdy;
		step_y = twice < pdx;
		at_end = (walk_x_q == x1) && (walk_y_q == y1);

		rx  = EW'(cmd_q.ax);
		ry  = EW'(cmd_q.ay);
		rxe = rx + EW'(cmd_q.rw) - EW'(1);
		rye = ry + EW'(cmd_q.rh) - EW'(1);
		ccx = rx;
		ccy = ry;
		circ_over = px_q > py_q;
		unique case (oct_q)
			3'd0: begin cpx = ccx + px_q; cpy = ccy + py_q; end
			3'd1: begin cpx = ccx - px_q; cpy = ccy + py_q; end
			3'd2: begin cpx = ccx + px_q; cpy = ccy - py_q; end
			3'd3: begin cpx = ccx - px_q; cpy = ccy - py_q; end
			3'd4: begin cpx = ccx + py_q; cpy = ccy + px_q; end
			3'd5: begin cpx = ccx - py_q; cpy = ccy + px_q; end
			3'd6: begin cpx = ccx + py_q; cpy = ccy - px_q; end
			default: begin cpx = ccx - py_q; cpy = ccy - px_q; end
		endcase
	end

	// plot request for the current cycle
	always_comb begin
		plot.valid    = 1'b0;
		plot.clear    = 1'b0;
		plot.clr_addr = clr_cnt_q;
		plot.x        = EW'(walk_x_q);
		plot.y        = EW'(walk_y_q);
		plot.color    = cmd_q.color;
		unique case (state_q)
			ST_CLEAR: begin
				plot.valid = 1'b1;
				plot.clear = 1'b1;
			end
			ST_LINE: plot.valid = 1'b1;
			ST_RECT_H: begin
				plot.valid = 1'b1;
				plot.x     = rx + EW'(i_q);
				plot.y     = phase_q ? rye : ry;
			end
			ST_RECT_V: begin
				plot.valid = 1'b1;
				plot.x     = phase_q ? rxe : rx;
				plot.y     = ry + EW'(i_q);
			end
			ST_CIRC: begin
				plot.valid = !(oct_q == 3'd0 && circ_over);
				plot.x     = cpx;
				plot.y     = cpy;
			end
			default: ;
		endcase
		rd.x = rx;
		rd.y = ry;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			clr_cmd_q <= 1'b0;
			seg_q     <= '0;
			walk_x_q  <= '0;
			walk_y_q  <= '0;
			err_q     <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (32'(clr_cnt_q) == srfb_pkg::CELL_COUNT - 1) begin
						state_q <= clr_cmd_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						seg_q     <= '0;
						clr_cnt_q <= '0;
						clr_cmd_q <= 1'b1;
						priority case (cmd.kind)
							srfb_pkg::KIND_LINE, srfb_pkg::KIND_TRI: state_q <= ST_LSETUP;
							srfb_pkg::KIND_RECT: begin
								state_q <= (cmd.rw == '0 || cmd.rh == '0) ? ST_DONE : ST_RECT_H;
							end
							srfb_pkg::KIND_CIRC:  state_q <= ST_CIRC;
							srfb_pkg::KIND_CLEAR: state_q <= ST_CLEAR;
							srfb_pkg::KIND_READ:  state_q <= ST_READ;
							default:              state_q <= ST_DONE;
						endcase
					end
				end
				ST_LSETUP: begin
					walk_x_q <= x0;
					walk_y_q <= y0;
					err_q    <= RW'({1'b0, adx}) - RW'({1'b0, ady});
					state_q  <= ST_LINE;
				end
				ST_LINE: begin
					if (at_end) begin
						if (cmd_q.kind == srfb_pkg::KIND_TRI && seg_q != 2'd2) begin
							seg_q   <= seg_q + 2'd1;
							state_q <= ST_LSETUP;
						end else begin
							seg_q   <= '0;
							state_q <= ST_DONE;
						end
					end else begin
						err_q <= RW'(32'(err_q) - (step_x ? 32'(dy_q) : 32'd0)
							+ (step_y ? 32'(dx_q) : 32'd0));
						if (step_x) begin
							walk_x_q <= sx_neg_q ? walk_x_q - CB'(1) : walk_x_q + CB'(1);
						end
						if (step_y) begin
							walk_y_q <= sy_neg_q ? walk_y_q - CB'(1) : walk_y_q + CB'(1);
						end
					end
				end
				ST_RECT_H: begin
					if (phase_q && i_q == cmd_q.rw - 1'b1) begin
						state_q <= ST_RECT_V;
					end
				end
				ST_RECT_V: begin
					if (phase_q && i_q == cmd_q.rh - 1'b1) begin
						state_q <= ST_DONE;
					end
				end
				ST_CIRC: begin
					if (oct_q == 3'd0 && circ_over) begin
						state_q <= ST_DONE;
					end
				end
				ST_READ:  state_q <= ST_RWAIT;
				ST_RWAIT: state_q <= ST_DONE;
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q   <= cmd;
				res_q   <= '0;
				i_q     <= '0;
				phase_q <= 1'b0;
				px_q    <= '0;
				py_q    <= EW'({1'b0, cmd.rad});
				d_q     <= DW'(3) - (DW'(cmd.rad) <<< 1);
				oct_q   <= '0;
			end
			ST_LSETUP: begin
				dx_q     <= adx;
				dy_q     <= ady;
				sx_neg_q <= !(x0 < x1);
				sy_neg_q <= !(y0 < y1);
			end
			ST_RECT_H, ST_RECT_V: begin
				phase_q <= !phase_q;
				if (phase_q) begin
					if ((state_q == ST_RECT_H && i_q == cmd_q.rw - 1'b1) ||
							(state_q == ST_RECT_V && i_q == cmd_q.rh - 1'b1)) begin
						i_q <= '0;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
			end
			ST_CIRC: begin
				if (!(oct_q == 3'd0 && circ_over)) begin
					oct_q <= oct_q + 3'd1;
					if (oct_q == 3'd7) begin
						// advance the midpoint decision after the eighth plot
						if (d_q[DW-1]) begin
							d_q <= d_q + (DW'(px_q) <<< 2) + DW'(6);
						end else begin
							d_q  <= d_q + (DW'(px_q - py_q) <<< 2) + DW'(10);
							py_q <= py_q - EW'(1);
						end
						px_q <= px_q + EW'(1);
					end
				end
			end
			ST_RWAIT: begin
				res_q.color    <= rsp.color;
				res_q.in_range <= rsp.in_canvas;
			end
			default: ;
		endcase
	end

endmodule

### rtl/shape_rasterizer_framebuffer_top.sv
// Channel   | Dir | Handshake                     | Payload
// s_axis    | in  | s_tvalid / s_tready           | s_tuser kind, s_tdata points, sizes, color
// m_axis    | out | m_tvalid / m_tready           | m_tuser read_in_range, m_tdata cell_color
// apb       | in  | psel, penable, pwrite, pready | 0x0 canvas_width, 0x4 canvas_height
//
// The plot path registers each plot request before it writes the cell store RAM and sets one cell per cycle.
// After reset a clearing pass over all 2048 cells runs with s_tready low.
// A finished result waits in the output register; a new command is taken meanwhile
// and holds in its last step until the register drains.
module shape_rasterizer_framebuffer_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	// ax[11:0] ay[23:12] bx[35:24] by[47:36] cx[59:48] cy[71:60]
	// rect_width[82:72] rect_height[93:83] radius[104:94] draw_color[107:105], zero pad
	input  logic [111:0] s_tdata,
	// kind[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// cell_color[2:0], zero pad
	output logic [7:0]   m_tdata,
	// read_in_range[0]
	output logic [0:0]   m_tuser
);

	logic [srfb_pkg::CW_W-1:0] cw_q;
	logic [srfb_pkg::CH_W-1:0] ch_q;
	srfb_pkg::cmd_t      cmd;
	srfb_pkg::result_t   res, out_q;
	logic                res_valid, res_ready, out_valid_q;
	srfb_pkg::plot_req_t plot;
	srfb_pkg::read_req_t rd;
	srfb_pkg::read_rsp_t rsp;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= srfb_pkg::CANVAS_W_RESET;
			ch_q <= srfb_pkg::CANVAS_H_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2]) begin
				ch_q <= pwdata[srfb_pkg::CH_W-1:0];
			end else begin
				cw_q <= pwdata[srfb_pkg::CW_W-1:0];
			end
		end
	end

	assign prdata = paddr[2] ? 32'(ch_q) : 32'(cw_q);

	always_comb begin
		cmd.kind  = s_tuser;
		cmd.ax    = s_tdata[11:0];
		cmd.ay    = s_tdata[23:12];
		cmd.bx    = s_tdata[35:24];
		cmd.by    = s_tdata[47:36];
		cmd.cx    = s_tdata[59:48];
		cmd.cy    = s_tdata[71:60];
		cmd.rw    = s_tdata[82:72];
		cmd.rh    = s_tdata[93:83];
		cmd.rad   = s_tdata[104:94];
		cmd.color = s_tdata[107:105];
	end

	srfb_draw u_draw (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.plot     (plot),
		.rd       (rd),
		.rsp      (rsp)
	);

	srfb_plot u_plot (
		.clk   (clk),
		.arst_n(arst_n),
		.plot  (plot),
		.rd    (rd),
		.cw    (cw_q),
		.ch    (ch_q),
		.rsp   (rsp)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = 8'(out_q.color);
	assign m_tuser  = out_q.in_range;

endmodule

### rtl/srfb_checker.sv
// Port-level checker for the shape rasterizer framebuffer, bound to the top level.
// Depends on shape_rasterizer_framebuffer_top_assert.svh.
`include "shape_rasterizer_framebuffer_top_assert.svh"

module srfb_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [7:0]   m_tdata,
	input logic [0:0]   m_tuser
);

	// one command in flight: no transfer right after an accepted one
	`SRFB_ASSERT_NEXT(a_one_cmd, s_tvalid && s_tready, !s_tready, "command taken back to back")
	// a result outside a canvas read carries background color
	`SRFB_ASSERT_NOW(a_bg_color, m_tvalid && !m_tuser[0], m_tdata == 8'd0, "color without read")
	// color fits three bits
	`SRFB_ASSERT_NOW(a_color_w, m_tvalid, m_tdata[7:3] == 5'd0, "color out of range")
	// hold a stalled result
	`SRFB_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

endmodule

bind shape_rasterizer_framebuffer_top srfb_checker u_srfb_checker (.*);
